[hdl/bc3_pkg.sv]
// bc3_pkg: shared constants, register codes and result type for the 3x3 binary closing block
// no dependencies; compile first
`default_nettype none

package bc3_pkg;

  // default frame limits, handed down as top level parameters
  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;

  // configuration port
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned RST_DIM   = 64;

  // result coordinates
  localparam int unsigned COORD_W = 10;

  // output queue depth and cycles from accept to queue entry
  localparam int unsigned OUT_DEPTH = 8;
  localparam int unsigned PIPE_LAT  = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic               closed_pixel;
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic               last_of_frame;
  } result_t;

endpackage

`default_nettype wire

[hdl/bc3_pix_if.sv]
// bc3_pix_if: valid/ready channel carrying one mask pixel per item
// depends on nothing
`default_nettype none

interface bc3_pix_if;
  logic valid;
  logic ready;
  logic in_pixel;

  modport source (output valid, output in_pixel, input ready);
  modport sink   (input valid, input in_pixel, output ready);
endinterface

`default_nettype wire

[hdl/bc3_res_if.sv]
// bc3_res_if: valid/ready channel carrying one closed pixel with its position per item
// depends on bc3_pkg for the coordinate width
`default_nettype none

interface bc3_res_if;
  import bc3_pkg::*;

  logic               valid;
  logic               ready;
  logic               closed_pixel;
  logic [COORD_W-1:0] out_col;
  logic [COORD_W-1:0] out_row;
  logic               last_of_frame;

  modport source (output valid, output closed_pixel, output out_col, output out_row,
                  output last_of_frame, input ready);
  modport sink   (input valid, input closed_pixel, input out_col, input out_row,
                  input last_of_frame, output ready);
endinterface

`default_nettype wire

[hdl/bc3_ram.sv]
// bc3_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module bc3_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/bc3_line_stage.sv]
// bc3_line_stage: one 3x3 neighborhood stage over a pixel stream, two rows of history
// per column in a bc3_ram, clamped at the frame edges; window lags the input by w+1 steps
// depends on bc3_ram
`default_nettype none

module bc3_line_stage #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 clear_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]       img_w_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]      img_h_i,
  input  logic                                 step_i,
  input  logic                                 bit_i,
  output logic                                 vld_o,
  output logic [8:0]                           win_o,
  output logic [$clog2(MAX_HEIGHT+2)-1:0]      row_o,
  output logic [$clog2(MAX_WIDTH)-1:0]         col_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 2);

  typedef struct packed {
    logic first_col;
    logic left_clamp;
    logic top_clamp;
    logic bot_clamp;
    logic emit;
  } stage_flags_t;

  // input position of the next step
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          last_col;
  logic          end_row;

  // step registered while the ram read is in flight
  logic          s1_vld_q;
  logic          s1_bit_q;
  logic [CW-1:0] s1_col_q;
  stage_flags_t  s1_flags_q, flags_d;
  logic [RW-1:0] s1_crow_q, crow_d;
  logic [CW-1:0] s1_ccol_q, ccol_d;

  // read-modify-write of the column history
  logic [1:0] ram_rdata;
  logic [1:0] col_hist;
  logic [1:0] wr_col;
  logic [1:0] fwd_q;
  logic       fwd_sel_q, fwd_sel_d;

  // vertical triples of the two previous columns
  logic [2:0] vcur;
  logic [2:0] vp1_q, vp2_q;
  logic [2:0] left, right;
  logic       top_bit, bot_bit;

  logic       vld_q;
  logic [8:0] win_q;
  logic [RW-1:0] row_q_o;
  logic [CW-1:0] col_q_o;

  // position counter, wraps after the last drain row
  assign last_col = (WW'(col_q) == img_w_i - WW'(1));
  assign end_row  = (row_q == RW'(img_h_i) + RW'(1));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (clear_i) begin
      col_d = '0;
      row_d = '0;
    end else if (step_i) begin
      if (end_row) begin
        col_d = '0;
        row_d = '0;
      end else if (last_col) begin
        col_d = '0;
        row_d = row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  // edge handling and center position of the window finished by this step
  always_comb begin
    flags_d.first_col  = (col_q == '0);
    flags_d.left_clamp = (col_q == CW'(1)) || ((col_q == '0) && (img_w_i == WW'(1)));
    flags_d.top_clamp  = (row_q == RW'(1));
    flags_d.bot_clamp  = (row_q >= RW'(img_h_i));
    flags_d.emit       = (row_q >= RW'(2)) || ((row_q == RW'(1)) && (col_q != '0));
    crow_d = (col_q == '0) ? row_q - RW'(2) : row_q - RW'(1);
    ccol_d = (col_q == '0) ? CW'(img_w_i - WW'(1)) : col_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      s1_vld_q  <= 1'b0;
      fwd_sel_q <= 1'b0;
      vld_q     <= 1'b0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      s1_vld_q  <= step_i;
      fwd_sel_q <= fwd_sel_d;
      vld_q     <= s1_vld_q && s1_flags_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      s1_bit_q   <= bit_i;
      s1_col_q   <= col_q;
      s1_flags_q <= flags_d;
      s1_crow_q  <= crow_d;
      s1_ccol_q  <= ccol_d;
    end
  end

  // column history: bit 1 is two rows up, bit 0 one row up
  bc3_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (s1_vld_q),
    .waddr_i (s1_col_q),
    .wdata_i (wr_col),
    .re_i    (step_i),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  // forward the write-back when the next step reads the same column
  assign fwd_sel_d = step_i && s1_vld_q && (col_q == s1_col_q);

  always_ff @(posedge clk_i) begin
    if (fwd_sel_d) begin
      fwd_q <= wr_col;
    end
  end

  assign col_hist = fwd_sel_q ? fwd_q : ram_rdata;
  assign wr_col   = {col_hist[0], s1_bit_q};

  // vertical triple with row clamping
  assign top_bit = s1_flags_q.top_clamp ? col_hist[0] : col_hist[1];
  assign bot_bit = s1_flags_q.bot_clamp ? col_hist[0] : s1_bit_q;
  assign vcur    = {top_bit, col_hist[0], bot_bit};

  // horizontal selection with column clamping
  assign right = s1_flags_q.first_col  ? vp1_q : vcur;
  assign left  = s1_flags_q.left_clamp ? vp1_q : vp2_q;

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      vp2_q   <= vp1_q;
      vp1_q   <= vcur;
      win_q   <= {left, vp1_q, right};
      row_q_o <= s1_crow_q;
      col_q_o <= s1_ccol_q;
    end
  end

  assign vld_o = vld_q;
  assign win_o = win_q;
  assign row_o = row_q_o;
  assign col_o = col_q_o;

endmodule

`default_nettype wire

[hdl/bc3_out_fifo.sv]
// bc3_out_fifo: small register queue for result items, reports its fill level
// depends on bc3_pkg for the result type
`default_nettype none

module bc3_out_fifo #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  bc3_pkg::result_t               push_data_i,
  input  logic                           pop_i,
  output logic                           valid_o,
  output bc3_pkg::result_t               data_o,
  output logic [$clog2(DEPTH+1)-1:0]     level_o
);

  import bc3_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned LW = $clog2(DEPTH + 1);

  result_t       mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [LW-1:0] cnt_q;
  logic          do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + LW'(1);
      end else if (do_pop && !push_i) begin
        cnt_q <= cnt_q - LW'(1);
      end
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign level_o = cnt_q;

endmodule

`default_nettype wire

[hdl/binary_close_3x3_top.sv]
// binary_close_3x3_top: streaming 3x3 binary closing (dilate then erode), edge replicated
// depends on bc3_pkg, bc3_pix_if, bc3_res_if, bc3_line_stage, bc3_out_fifo
//
//   channel   dir  payload                                           accepted when
//   pix_i     in   in_pixel                                          valid && ready
//   res_o     out  closed_pixel, out_col, out_row, last_of_frame     valid && ready
//   cfg_*     in   cfg_idx_i selects image_width / image_height      cfg_we_i
//
// One item per clock while ready is high. In each of the two stages a step passes a
// line-memory read register and then a window update register; stage two feeds the output queue.
// Each stage keeps two rows of history per column in one ram, read and written back per item,
// with forwarding when consecutive items hit the same column.
// ready drops only when queued plus in-flight items would overrun the 8-entry output queue.
// Reset clears control state only; line memories need no clearing pass.
// A configuration write restarts the frame.
`default_nettype none

module binary_close_3x3_top #(
  parameter int unsigned MAX_WIDTH  = bc3_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = bc3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bc3_pix_if.sink                        pix_i,
  bc3_res_if.source                      res_o,
  input  logic                           cfg_we_i,
  input  logic [bc3_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bc3_pkg::CFG_W-1:0]      cfg_data_i
);

  import bc3_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned NW = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 3);
  localparam int unsigned LW = $clog2(OUT_DEPTH + 1);

  localparam int unsigned RST_W   = (RST_DIM > MAX_WIDTH) ? MAX_WIDTH : RST_DIM;
  localparam int unsigned RST_H   = (RST_DIM > MAX_HEIGHT) ? MAX_HEIGHT : RST_DIM;
  localparam int unsigned RST_TOT = RST_W * RST_H;

  function automatic logic [31:0] clamp_dim(logic [CFG_W-1:0] v, logic [31:0] hi);
    logic [31:0] x;
    x = 32'(v);
    if (x == 32'd0) begin
      return 32'd1;
    end
    if (x > hi) begin
      return hi;
    end
    return x;
  endfunction

  // frame geometry and item counter
  logic [WW-1:0] w_q, w_d;
  logic [HW-1:0] h_q, h_d;
  logic [NW-1:0] lim_a_q, end_q, tot_d;
  logic [NW-1:0] n_q;
  logic          cfg_hit;

  logic          accept;
  logic          a_step;
  logic          last_item;

  // drain steps of the second stage, aligned with the first stage's window output
  logic          b_drain;
  logic [1:0]    drain_q;
  logic          b_step;

  // stage outputs
  logic          a_vld, b_vld;
  logic [8:0]    a_win, b_win;
  logic [RW-1:0] a_row, b_row;
  logic [CW-1:0] a_col, b_col;

  // output side
  logic [PIPE_LAT-1:0] acc_q;
  logic [2:0]          infl;
  logic [LW-1:0]       fifo_level;
  logic                fifo_valid;
  result_t             fifo_data;
  result_t             res_d;

  // register writes, clamped and with derived frame limits
  always_comb begin
    w_d     = w_q;
    h_d     = h_q;
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_IMAGE_WIDTH: begin
          w_d     = WW'(clamp_dim(cfg_data_i, 32'(MAX_WIDTH)));
          cfg_hit = 1'b1;
        end
        REG_IMAGE_HEIGHT: begin
          h_d     = HW'(clamp_dim(cfg_data_i, 32'(MAX_HEIGHT)));
          cfg_hit = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
    tot_d = NW'(w_d) * NW'(h_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q     <= WW'(RST_W);
      h_q     <= HW'(RST_H);
      lim_a_q <= NW'(RST_TOT + RST_W);
      end_q   <= NW'(RST_TOT + 2 * RST_W + 1);
    end else if (cfg_hit) begin
      w_q     <= w_d;
      h_q     <= h_d;
      lim_a_q <= tot_d + NW'(w_d);
      end_q   <= tot_d + NW'(w_d) + NW'(w_d) + NW'(1);
    end
  end

  // items since frame start; the first stage takes pixels and w+1 drain items
  assign accept    = pix_i.valid && pix_i.ready;
  assign a_step    = accept && (n_q <= lim_a_q);
  assign last_item = (n_q == end_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
    end else if (cfg_hit) begin
      n_q <= '0;
    end else if (accept) begin
      n_q <= last_item ? '0 : n_q + NW'(1);
    end
  end

  // the remaining w+1 items of a frame step only the second stage, delayed through drain_q to align
  assign b_drain = accept && (n_q > lim_a_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q <= '0;
    end else begin
      drain_q <= {drain_q[0], b_drain};
    end
  end

  assign b_step = a_vld || drain_q[1];

  // dilation over the raw mask
  bc3_line_stage #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dilate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (cfg_hit),
    .img_w_i (w_q),
    .img_h_i (h_q),
    .step_i  (a_step),
    .bit_i   (pix_i.in_pixel),
    .vld_o   (a_vld),
    .win_o   (a_win),
    .row_o   (a_row),
    .col_o   (a_col)
  );

  // erosion over the dilated mask
  bc3_line_stage #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_erode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (cfg_hit),
    .img_w_i (w_q),
    .img_h_i (h_q),
    .step_i  (b_step),
    .bit_i   (|a_win),
    .vld_o   (b_vld),
    .win_o   (b_win),
    .row_o   (b_row),
    .col_o   (b_col)
  );

  // result item
  always_comb begin
    res_d.closed_pixel  = &b_win;
    res_d.out_col       = COORD_W'(b_col);
    res_d.out_row       = COORD_W'(b_row);
    res_d.last_of_frame = (b_row == RW'(h_q) - RW'(1)) && (WW'(b_col) == w_q - WW'(1));
  end

  bc3_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (b_vld),
    .push_data_i (res_d),
    .pop_i       (res_o.ready),
    .valid_o     (fifo_valid),
    .data_o      (fifo_data),
    .level_o     (fifo_level)
  );

  // items in flight toward the queue, each may bring a result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= {acc_q[PIPE_LAT-2:0], accept};
    end
  end

  always_comb begin
    infl = '0;
    for (int i = 0; i < PIPE_LAT; i++) begin
      infl = infl + 3'(acc_q[i]);
    end
  end

  assign pix_i.ready = (32'(fifo_level) + 32'(infl) + 32'd1) <= 32'(OUT_DEPTH);

  assign res_o.valid         = fifo_valid;
  assign res_o.closed_pixel  = fifo_data.closed_pixel;
  assign res_o.out_col       = fifo_data.out_col;
  assign res_o.out_row       = fifo_data.out_row;
  assign res_o.last_of_frame = fifo_data.last_of_frame;

  // first stage position is not needed downstream
  logic unused_a;
  assign unused_a = ^{a_row, a_col};

endmodule

`default_nettype wire
